### src/lbspm_pkg.sv
// Shared types, constants and elaboration-time functions of the band peak meter.
// Used by lbspm_band_track, lbspm_isqrt and log_band_spectrum_peak_meter; depends on nothing.
package lbspm_pkg;

    localparam int MAG_W          = 16;
    localparam int HEIGHT_W       = 10;
    localparam int BAND_W         = 6;
    localparam int POS_W          = 10;
    localparam int EDGE_SLOTS     = 64;
    localparam int BAND_COUNT_DEF = 16;
    localparam int BIN_MAX        = 1023;
    localparam int EDGE_EXP_STEP  = 10;
    localparam int LEVEL_OFFSET   = 4;
    localparam int LEVEL_SHIFT    = 8;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd127;

    // Height times three, its square, and the radicand 9*h*h*peak.
    localparam int H3_W   = HEIGHT_W + 2;
    localparam int HH_W   = 2 * H3_W;
    localparam int RAD_W  = HH_W + MAG_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int Q_W    = ROOT_W - LEVEL_SHIFT;

    // Width used for exact powers at elaboration: 1024^63 is 2^630.
    localparam int BIG_W = 720;

    typedef logic [POS_W-1:0] edge_tab_t [0:EDGE_SLOTS-1];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_ROOT,
        ST_HOLD
    } lbspm_state_t;

    // What the band tracker reports about the bin on its input.
    typedef struct packed {
        logic              hit;
        logic              last;
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  peak;
    } band_event_t;

    // True when k^b <= 2^a, exact.
    function automatic logic pow_fits(int k, int b, int a);
        logic [BIG_W-1:0] acc;
        int i;
        acc = BIG_W'(1);
        for (i = 0; i < b; i++)
        begin
            acc = acc * BIG_W'(k);
        end
        return acc <= (BIG_W'(1) << a);
    endfunction

    // Largest k in 1..1024 with k^b <= 2^a.
    function automatic int floor_pow2(int a, int b);
        int lo;
        int hi;
        int mid;
        lo = 1;
        hi = 1024;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (pow_fits(mid, b, a))
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Last bin of every band; entries past the band count stay zero.
    function automatic edge_tab_t build_edges(int bands);
        edge_tab_t t;
        int x;
        int b0;
        int b1;
        t  = '{default: '0};
        b0 = 0;
        for (x = 0; x < bands && x < EDGE_SLOTS; x++)
        begin
            b1 = floor_pow2(EDGE_EXP_STEP * x, bands - 1);
            if (b1 > BIN_MAX)
                b1 = BIN_MAX;
            if (b1 <= b0)
                b1 = b0 + 1;
            t[x] = POS_W'(b1);
            b0   = b1;
        end
        return t;
    endfunction

endpackage

### src/lbspm_band_track.sv
// Bin counter, band counter and running peak of the band peak meter.
// Depends on lbspm_pkg for widths, the band event struct and the edge table builder.
module lbspm_band_track #(
    parameter int BAND_COUNT = lbspm_pkg::BAND_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [lbspm_pkg::MAG_W-1:0]    magnitude,
    input  logic                           frame_last,
    output lbspm_pkg::band_event_t         evt
);

    localparam lbspm_pkg::edge_tab_t EDGES = lbspm_pkg::build_edges(BAND_COUNT);
    localparam logic [lbspm_pkg::BAND_W-1:0] LAST_BAND = lbspm_pkg::BAND_W'(BAND_COUNT - 1);

    logic [lbspm_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [lbspm_pkg::BAND_W-1:0] band_reg, band_next;
    logic [lbspm_pkg::MAG_W-1:0]  peak_reg, peak_next;

    logic                          pos_nz;
    logic [lbspm_pkg::MAG_W-1:0]  peak_upd;
    logic [lbspm_pkg::POS_W-1:0]  pos_inc;

    always_comb
    begin
        pos_nz   = (pos_reg != '0);
        peak_upd = peak_reg;
        if (pos_nz && magnitude > peak_reg)
            peak_upd = magnitude;

        evt.hit  = pos_nz && (pos_reg == EDGES[band_reg]);
        evt.last = (band_reg == LAST_BAND);
        evt.band = band_reg;
        evt.peak = peak_upd;

        pos_inc   = pos_reg + 1'b1;
        pos_next  = pos_inc;
        band_next = band_reg;
        peak_next = peak_upd;
        if (evt.hit)
        begin
            peak_next = '0;
            if (band_reg != LAST_BAND)
                band_next = band_reg + 1'b1;
        end
        // End of frame, or the bin counter wrapped: start a fresh frame.
        if (frame_last || pos_inc == '0)
        begin
            pos_next  = '0;
            band_next = '0;
            peak_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            band_reg <= '0;
            peak_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            band_reg <= band_next;
            peak_reg <= peak_next;
        end
    end

endmodule

### src/lbspm_isqrt.sv
// Iterative integer square root, one result bit per cycle, restoring method.
// Depends on lbspm_pkg for the radicand and root widths.
module lbspm_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lbspm_pkg::RAD_W-1:0]   radicand,
    output logic                          done,
    output logic [lbspm_pkg::ROOT_W-1:0]  root
);

    localparam int ROOT_W = lbspm_pkg::ROOT_W;
    localparam int RAD_W  = lbspm_pkg::RAD_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TRY_W-1:0]  rem_shift;
    logic [TRY_W-1:0]  trial;
    logic              take;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = TRY_W'({root_reg, 2'b01});
        take      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### src/log_band_spectrum_peak_meter.sv
// Top level of the logarithmic spectrum band peak meter: sequencer and output register.
// Depends on lbspm_pkg, lbspm_band_track and lbspm_isqrt.

// The block takes frames of 1024 FFT magnitude bins, one bin per slave-side transfer,
// with tlast on the final bin. Bin 0 is skipped; bins 1 to 1023 fall into BAND_COUNT
// bands whose last bins follow floor(2^(10x/(BAND_COUNT-1))), capped at 1023, with at
// least one bin per band. On the bin that closes a band, one master-side transfer
// carries the band number and its level, floor(sqrt(peak/65536)*3*height - 4) clamped
// to 0..height, where height is the configuration register (reset 127). After a bin
// that closes a band, no bin is accepted until the sequencer has squared three times
// the height, scaled it by the peak, run the bit-serial square root (20 root bits,
// one per cycle through a single compare-subtract unit, then the root is handed over)
// and loaded the output register; that load waits while the register is still full.
// A finished result waits in the output register, so the next bins are taken while
// it waits. A short frame leaves its unfinished bands unreported; the height should
// be written only while no band result is pending.
module log_band_spectrum_peak_meter #(
    parameter int BAND_COUNT = lbspm_pkg::BAND_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: level_height.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    // Bins in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] magnitude
    input  logic        s_tlast,    // frame_last
    // Band levels out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [5:0] band_index, [15:6] level
    output logic        m_tlast     // band_last
);

    localparam int HEIGHT_W = lbspm_pkg::HEIGHT_W;
    localparam int BAND_W   = lbspm_pkg::BAND_W;
    localparam int MAG_W    = lbspm_pkg::MAG_W;
    localparam int H3_W     = lbspm_pkg::H3_W;
    localparam int HH_W     = lbspm_pkg::HH_W;
    localparam int RAD_W    = lbspm_pkg::RAD_W;
    localparam int ROOT_W   = lbspm_pkg::ROOT_W;
    localparam int Q_W      = lbspm_pkg::Q_W;
    localparam logic [Q_W-1:0] Q_OFFSET = Q_W'(lbspm_pkg::LEVEL_OFFSET);
    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BAND_COUNT - 1);

    lbspm_pkg::lbspm_state_t state_reg, state_next;
    lbspm_pkg::band_event_t  evt;

    logic [HEIGHT_W-1:0] height_reg;

    logic [MAG_W-1:0]    peak_reg;
    logic [BAND_W-1:0]   band_reg;
    logic                blast_reg;
    logic [HH_W-1:0]     hh_reg;
    logic [HEIGHT_W-1:0] lvl_reg, lvl_next;

    logic                out_valid_reg;
    logic [BAND_W-1:0]   out_band_reg;
    logic [HEIGHT_W-1:0] out_level_reg;
    logic                out_last_reg;

    logic                in_accept;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic [RAD_W-1:0]    radicand;
    logic [H3_W-1:0]     h3;
    logic [Q_W-1:0]      q;
    logic [Q_W-1:0]      q_sub;
    logic                out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == lbspm_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            height_reg <= lbspm_pkg::HEIGHT_RESET;
        else if (cfg_valid && cfg_ready)
            height_reg <= cfg_data;
    end

    lbspm_band_track #(
        .BAND_COUNT (BAND_COUNT)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .magnitude  (s_tdata[MAG_W-1:0]),
        .frame_last (s_tlast),
        .evt        (evt)
    );

    // Radicand 9*h*h*peak; the product feeds the root unit's input register directly.
    assign h3       = H3_W'(height_reg) + H3_W'({height_reg, 1'b0});
    assign radicand = RAD_W'(hh_reg) * RAD_W'(peak_reg);

    lbspm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Level: drop the eight fraction bits of the root, subtract the offset, clamp.
    always_comb
    begin
        q     = sqrt_root[ROOT_W-1 -: Q_W];
        q_sub = q - Q_OFFSET;
        if (q < Q_OFFSET)
            lvl_next = '0;
        else if (q_sub > Q_W'(height_reg))
            lvl_next = height_reg;
        else
            lvl_next = q_sub[HEIGHT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            lbspm_pkg::ST_IDLE:
            begin
                if (in_accept && evt.hit)
                    state_next = lbspm_pkg::ST_SQUARE;
            end
            lbspm_pkg::ST_SQUARE:
            begin
                state_next = lbspm_pkg::ST_SCALE;
            end
            lbspm_pkg::ST_SCALE:
            begin
                sqrt_start = 1'b1;
                state_next = lbspm_pkg::ST_ROOT;
            end
            lbspm_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                    state_next = lbspm_pkg::ST_HOLD;
            end
            lbspm_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = lbspm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbspm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbspm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers of the band being reported.
    always_ff @(posedge clk)
    begin
        if (in_accept && evt.hit)
        begin
            peak_reg  <= evt.peak;
            band_reg  <= evt.band;
            blast_reg <= evt.last;
        end
        if (state_reg == lbspm_pkg::ST_SQUARE)
            hh_reg <= HH_W'(h3) * HH_W'(h3);
        if (state_reg == lbspm_pkg::ST_ROOT && sqrt_done)
            lvl_reg <= lvl_next;
    end

    // Output register: holds a result until the master side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_band_reg  <= band_reg;
            out_level_reg <= lvl_reg;
            out_last_reg  <= blast_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_level_reg, out_band_reg};
    assign m_tlast  = out_last_reg;

    // The level never exceeds the configured height.
    a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:6] <= height_reg))
        else $error("band level above configured height");

    // Only the final band carries tlast.
    a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] == LAST_BAND))
        else $error("tlast on a band other than the last");

    // A bin that closes a band blocks the input until its level is done.
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && evt.hit) |=> !s_tready)
        else $error("input accepted while a band level is in progress");

    // The root unit finishes only while the sequencer waits for it.
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == lbspm_pkg::ST_ROOT))
        else $error("square root finished outside the root state");

    // A new result is loaded only when the previous one has left.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> m_tready)
        else $error("pending band result overwritten");

endmodule
